// File: sv/rpa_pkg.sv
// ----------------------------------------------------------------------------
// rpa_pkg
// Shared types and constants for the reference-counted page allocator.
// ----------------------------------------------------------------------------
package rpa_pkg;

    localparam int ADDR_W    = 40;
    localparam int OP_W      = 2;
    localparam int STAT_W    = 2;
    localparam int CNT_OUT_W = 16;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 64;
    localparam int CFG_IDX_W = 1;

    // Register map of the configuration channel
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_BASE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_TOP  = 1'd1;

    localparam logic [ADDR_W-1:0] REGION_BASE_RST = 40'h00_8000_0000;
    localparam logic [ADDR_W-1:0] REGION_TOP_RST  = 40'h00_8800_0000;

    // Result status codes
    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_OOM      = 2'd1;
    localparam logic [STAT_W-1:0] STAT_BAD_ADDR = 2'd2;
    localparam logic [STAT_W-1:0] STAT_CNT_ERR  = 2'd3;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC  = 2'd0,
        OP_INCREF = 2'd1,
        OP_DECREF = 2'd2,
        OP_INIT   = 2'd3
    } t_opcode;

    // Controller to datapath
    typedef struct packed {
        logic accept;   // input transfer: latch item, launch memory reads
        logic sweep;    // clear one count entry and seed one stack entry
        logic exec;     // write back and load the result register
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        t_opcode in_op;
        logic    sweep_last;
    } t_sts;

endpackage

// File: sv/rpa_ram.sv
// ----------------------------------------------------------------------------
// rpa_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module rpa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: sv/rpa_ctrl.sv
// ----------------------------------------------------------------------------
// rpa_ctrl
// Sequencer: clear pass after reset, input transfer, init fill, write back.
// ----------------------------------------------------------------------------
module rpa_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    output rpa_pkg::t_cmd o_cmd,
    input  rpa_pkg::t_sts i_sts
);
    import rpa_pkg::*;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_FILL,
        S_EXEC
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_m_valid;
    logic   w_accept;
    logic   w_out_free;

    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    // result register can take a new result
    assign w_out_free = !r_m_valid || i_m_tready;

    assign o_cmd.accept = w_accept;
    assign o_cmd.sweep  = (r_state == S_CLEAR) || (r_state == S_FILL);
    assign o_cmd.exec   = (r_state == S_EXEC) && w_out_free;
    assign o_m_tvalid   = r_m_valid;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_sts.sweep_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_state = (i_sts.in_op == OP_INIT) ? S_FILL : S_EXEC;
                end
            end
            S_FILL: begin
                if (i_sts.sweep_last) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.exec) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    a_exec_shows_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.exec |=> o_m_tvalid)
        else $error("result not presented after write back");

    a_no_accept_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.accept && o_cmd.sweep))
        else $error("input transfer during sweep");

    a_one_item_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> !o_s_tready)
        else $error("second item taken while one is in flight");

endmodule

// File: sv/rpa_dp.sv
// ----------------------------------------------------------------------------
// rpa_dp
// Datapath: config registers, address check, free stack, count memory, result.
// ----------------------------------------------------------------------------
module rpa_dp #(
    parameter int NUM_PAGES  = 32768,
    parameter int PAGE_SHIFT = 12,
    parameter int COUNT_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [rpa_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rpa_pkg::ADDR_W-1:0]     i_cfg_data,
    input  logic [rpa_pkg::S_TDATA_W-1:0]  i_s_tdata,
    input  logic [rpa_pkg::OP_W-1:0]       i_s_tuser,
    output logic [rpa_pkg::M_TDATA_W-1:0]  o_m_tdata,
    input  rpa_pkg::t_cmd                  i_cmd,
    output rpa_pkg::t_sts                  o_sts
);
    import rpa_pkg::*;

    localparam int IDX_W   = $clog2(NUM_PAGES);
    localparam int DEPTH_W = $clog2(NUM_PAGES + 1);
    localparam int EB_W    = ADDR_W + 1;          // rounded base may carry out
    localparam int POFF_W  = EB_W - PAGE_SHIFT;
    localparam int CEXT_W  = (COUNT_BITS > CNT_OUT_W) ? COUNT_BITS : CNT_OUT_W;
    localparam int PAD_W   = M_TDATA_W - ADDR_W - STAT_W - 1 - CNT_OUT_W;

    localparam logic [EB_W-1:0]       PG_MASK   = EB_W'((64'd1 << PAGE_SHIFT) - 64'd1);
    localparam logic [EB_W-1:0]       EB_RST    = ({1'b0, REGION_BASE_RST} + PG_MASK)
                                                  & ~PG_MASK;
    localparam logic [DEPTH_W-1:0]    N_PAGES_D = DEPTH_W'(NUM_PAGES);
    localparam logic [POFF_W-1:0]     N_PAGES_P = POFF_W'(NUM_PAGES);
    localparam logic [IDX_W-1:0]      LAST_IDX  = IDX_W'(NUM_PAGES - 1);
    localparam logic [COUNT_BITS-1:0] CNT_MAX   = {COUNT_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] CNT_ONE   = COUNT_BITS'(1);

    // configuration
    logic [EB_W-1:0]   r_eff_base;
    logic [ADDR_W-1:0] r_top;

    // latched item
    t_opcode           r_op;
    logic              r_addr_ok;
    logic [IDX_W-1:0]  r_idx;
    logic [DEPTH_W-1:0] r_fill_n;

    // stack pointer and sweep counter
    logic [DEPTH_W-1:0] r_depth;
    logic [DEPTH_W-1:0] n_depth;
    logic [IDX_W-1:0]   r_ctr;
    logic [IDX_W-1:0]   n_ctr;

    // result register
    logic [ADDR_W-1:0]    r_res_addr;
    logic [STAT_W-1:0]    r_status;
    logic                 r_freed;
    logic [CNT_OUT_W-1:0] r_count;

    // address check on the incoming item
    logic [ADDR_W-1:0] w_addr;
    logic [EB_W-1:0]   w_off;
    logic [POFF_W-1:0] w_poff;
    logic              w_addr_ok;

    // pool size for init
    logic [EB_W-1:0]    w_span;
    logic [POFF_W-1:0]  w_span_pg;
    logic [DEPTH_W-1:0] w_fill_n;

    // memories
    logic [COUNT_BITS-1:0] w_cnt_rd;
    logic [IDX_W-1:0]      w_stk_rd;
    logic                  w_cnt_we;
    logic [IDX_W-1:0]      w_cnt_wa;
    logic [COUNT_BITS-1:0] w_cnt_wd;
    logic                  w_stk_we;
    logic [IDX_W-1:0]      w_stk_wa;
    logic [IDX_W-1:0]      w_stk_wd;
    logic [IDX_W-1:0]      w_pop_ra;

    // write-back results
    logic [ADDR_W-1:0]     w_res_addr;
    logic [STAT_W-1:0]     w_status;
    logic                  w_freed;
    logic [COUNT_BITS-1:0] w_count;
    logic [CEXT_W-1:0]     w_count_ext;
    logic [EB_W-1:0]       w_alloc_sum;

    assign o_cfg_ready = 1'b1;

    // ---- address check ----
    assign w_addr = i_s_tdata[ADDR_W-1:0];
    assign w_off  = {1'b0, w_addr} - r_eff_base;
    assign w_poff = w_off[EB_W-1:PAGE_SHIFT];
    assign w_addr_ok = ((w_addr & PG_MASK[ADDR_W-1:0]) == '0)
                    && ({1'b0, w_addr} >= r_eff_base)
                    && (w_addr < r_top)
                    && (w_poff < N_PAGES_P);

    // ---- init pool size, clamped ----
    assign w_span    = {1'b0, r_top} - r_eff_base;
    assign w_span_pg = w_span[EB_W-1:PAGE_SHIFT];
    always_comb begin
        if ({1'b0, r_top} <= r_eff_base) begin
            w_fill_n = '0;
        end else if (w_span_pg >= N_PAGES_P) begin
            w_fill_n = N_PAGES_D;
        end else begin
            w_fill_n = DEPTH_W'(w_span_pg);
        end
    end

    assign o_sts.in_op      = t_opcode'(i_s_tuser);
    assign o_sts.sweep_last = (r_ctr == LAST_IDX);

    assign w_pop_ra = IDX_W'(r_depth - DEPTH_W'(1));

    // ---- write back ----
    assign w_alloc_sum = r_eff_base + (EB_W'(w_stk_rd) << PAGE_SHIFT);

    always_comb begin
        w_res_addr = '0;
        w_status   = STAT_OK;
        w_freed    = 1'b0;
        w_count    = '0;
        w_cnt_we   = 1'b0;
        w_cnt_wa   = r_idx;
        w_cnt_wd   = '0;
        w_stk_we   = 1'b0;
        w_stk_wa   = IDX_W'(r_depth);
        w_stk_wd   = r_idx;
        n_depth    = r_depth;
        unique case (r_op)
            OP_ALLOC: begin
                if (r_depth == '0) begin
                    w_status = STAT_OOM;
                end else begin
                    w_cnt_we   = 1'b1;
                    w_cnt_wa   = w_stk_rd;
                    w_cnt_wd   = CNT_ONE;
                    w_count    = CNT_ONE;
                    w_res_addr = w_alloc_sum[ADDR_W-1:0];
                    n_depth    = r_depth - DEPTH_W'(1);
                end
            end
            OP_INCREF: begin
                if (!r_addr_ok) begin
                    w_status = STAT_BAD_ADDR;
                end else if (w_cnt_rd == CNT_MAX) begin
                    w_status = STAT_CNT_ERR;
                    w_count  = w_cnt_rd;
                end else begin
                    w_cnt_we = 1'b1;
                    w_cnt_wd = w_cnt_rd + CNT_ONE;
                    w_count  = w_cnt_wd;
                end
            end
            OP_DECREF: begin
                if (!r_addr_ok) begin
                    w_status = STAT_BAD_ADDR;
                end else if (w_cnt_rd == '0) begin
                    w_status = STAT_CNT_ERR;
                end else begin
                    w_cnt_we = 1'b1;
                    w_cnt_wd = w_cnt_rd - CNT_ONE;
                    w_count  = w_cnt_wd;
                    // last reference gone: push unless the stack is full
                    if ((w_cnt_rd == CNT_ONE) && (r_depth < N_PAGES_D)) begin
                        w_stk_we = 1'b1;
                        w_freed  = 1'b1;
                        n_depth  = r_depth + DEPTH_W'(1);
                    end
                end
            end
            OP_INIT: begin
                n_depth = r_fill_n;
            end
            default: n_depth = r_depth;
        endcase
        if (!i_cmd.exec) begin
            w_cnt_we = 1'b0;
            w_stk_we = 1'b0;
            n_depth  = r_depth;
        end
        // sweep: zero a count, seed the stack with its own index
        if (i_cmd.sweep) begin
            w_cnt_we = 1'b1;
            w_cnt_wa = r_ctr;
            w_cnt_wd = '0;
            w_stk_we = 1'b1;
            w_stk_wa = r_ctr;
            w_stk_wd = r_ctr;
        end
    end

    assign w_count_ext = CEXT_W'(w_count);

    always_comb begin
        n_ctr = r_ctr;
        if (i_cmd.accept) begin
            n_ctr = '0;
        end else if (i_cmd.sweep) begin
            n_ctr = (r_ctr == LAST_IDX) ? '0 : r_ctr + IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eff_base <= EB_RST;
            r_top      <= REGION_TOP_RST;
            r_depth    <= '0;
            r_ctr      <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_REGION_BASE) begin
                    r_eff_base <= ({1'b0, i_cfg_data} + PG_MASK) & ~PG_MASK;
                end else if (i_cfg_index == CFG_REGION_TOP) begin
                    r_top <= i_cfg_data;
                end
            end
            r_depth <= n_depth;
            r_ctr   <= n_ctr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op      <= t_opcode'(i_s_tuser);
            r_addr_ok <= w_addr_ok;
            r_idx     <= w_poff[IDX_W-1:0];
            r_fill_n  <= w_fill_n;
        end
        if (i_cmd.exec) begin
            r_res_addr <= w_res_addr;
            r_status   <= w_status;
            r_freed    <= w_freed;
            r_count    <= w_count_ext[CNT_OUT_W-1:0];
        end
    end

    assign o_m_tdata = {{PAD_W{1'b0}}, r_count, r_freed, r_status, r_res_addr};

    rpa_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (NUM_PAGES)
    ) u_counts (
        .i_clk     (i_clk),
        .i_we      (w_cnt_we),
        .i_wr_addr (w_cnt_wa),
        .i_wr_data (w_cnt_wd),
        .i_rd_en   (i_cmd.accept),
        .i_rd_addr (w_poff[IDX_W-1:0]),
        .o_rd_data (w_cnt_rd)
    );

    rpa_ram #(
        .WIDTH (IDX_W),
        .DEPTH (NUM_PAGES)
    ) u_stack (
        .i_clk     (i_clk),
        .i_we      (w_stk_we),
        .i_wr_addr (w_stk_wa),
        .i_wr_data (w_stk_wd),
        .i_rd_en   (i_cmd.accept),
        .i_rd_addr (w_pop_ra),
        .o_rd_data (w_stk_rd)
    );

    a_depth_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= N_PAGES_D)
        else $error("free stack depth beyond page count");

    a_bad_addr_no_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && (r_op == OP_DECREF) && !r_addr_ok) |=> (r_depth == $past(r_depth)))
        else $error("bad address changed the free stack");

endmodule

// File: sv/refcounted_page_allocator_core.sv
// ----------------------------------------------------------------------------
// refcounted_page_allocator_core
// Page allocator with a LIFO free stack and a reference count per page.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: tuser = opcode (alloc, incref, decref/free, init), tdata =
//   page address for incref/decref. Master stream: one result per item.
//   Config channel: index 0 region_base, 1 region_top; taken every cycle,
//   write only while no item is in flight.
//   Alloc/incref/decref: the input transfer launches the reads of the count
//   and free-stack memories, whose read data is registered; the write back,
//   which also loads the result register, follows in the exec state once
//   the result register is free to take a new result.
//   Init: sweeps every page slot, one per cycle, clearing its count and
//   seeding the stack.
//   Reset: a clearing pass over every page slot zeroes all counts; tready
//   stays low until it ends. The stack is empty after reset.
//   Stall: a result waits in the output register; the next item may be
//   taken, but its write back holds until the previous result is taken.
// ----------------------------------------------------------------------------
module refcounted_page_allocator_core #(
    parameter int NUM_PAGES  = 32768,
    parameter int PAGE_SHIFT = 12,
    parameter int COUNT_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration writes
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [rpa_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [rpa_pkg::ADDR_W-1:0]    i_cfg_data,
    // request stream
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [rpa_pkg::S_TDATA_W-1:0] i_s_tdata,   // [39:0] page_address
    input  logic [rpa_pkg::OP_W-1:0]      i_s_tuser,   // [1:0] opcode
    // result stream
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // [39:0] result_address, [41:40] status, [42] page_freed,
    // [58:43] new_count, [63:59] zero
    output logic [rpa_pkg::M_TDATA_W-1:0] o_m_tdata
);
    import rpa_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    // sequencing: clear pass, transfers, init sweep, write back
    rpa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_cmd      (w_cmd),
        .i_sts      (w_sts)
    );

    // registers, address check, memories and result register
    rpa_dp #(
        .NUM_PAGES  (NUM_PAGES),
        .PAGE_SHIFT (PAGE_SHIFT),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tdata   (o_m_tdata),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts)
    );

endmodule

// File: tb/sv/tb_refcounted_page_allocator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_refcounted_page_allocator_core
// Self-checking bench for the reference-counted page allocator.
// Requests go in on the slave stream, and a local model of the free stack and
// the page counts predicts each result. Results are checked field by field,
// in order. Directed tests cover empty, small, oversized, degenerate and
// moved regions. Random phases follow, with random regions, random idling
// on both streams and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_refcounted_page_allocator_core;
    import rpa_pkg::*;

    localparam int NUM_PAGES    = 32768;
    localparam int PAGE_SHIFT   = 12;
    localparam int COUNT_BITS   = 16;
    localparam int CLK_PERIOD   = 20;
    localparam int SLOT_W       = $clog2(NUM_PAGES);
    localparam int SETTLE       = 8;              // idle cycles before a register write
    localparam int HOLDOFF_LEN  = 400;            // long receiver stall
    localparam int STALL_LIMIT  = 4 * NUM_PAGES + 1000;  // init sweep is the longest gap
    localparam logic [63:0]           PAGE_MASK = (64'd1 << PAGE_SHIFT) - 1;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // One result, result_address in the low bits as on o_m_tdata
    typedef struct packed {
        logic [CNT_OUT_W-1:0] new_count;
        logic                 page_freed;
        logic [STAT_W-1:0]    status;
        logic [ADDR_W-1:0]    result_address;
    } t_page_result;

    localparam int RES_W = $bits(t_page_result);

    // ------------------------------------------------------------------------
    // DUT ports, all inputs known from time zero
    // ------------------------------------------------------------------------
    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_REGION_BASE;
    logic [ADDR_W-1:0]    i_cfg_data  = '0;
    logic                 i_s_tvalid  = 1'b0;
    logic                 o_s_tready;
    logic [S_TDATA_W-1:0] i_s_tdata   = '0;   // [39:0] page_address
    logic [OP_W-1:0]      i_s_tuser   = OP_ALLOC;  // [1:0] opcode
    logic                 o_m_tvalid;
    logic                 i_m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] o_m_tdata;  // [39:0] addr, [41:40] status, [42] freed, [58:43] count

    refcounted_page_allocator_core #(
        .NUM_PAGES  (NUM_PAGES),
        .PAGE_SHIFT (PAGE_SHIFT),
        .COUNT_BITS (COUNT_BITS)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Allocator model state: registers, free stack and counts as after reset
    // ------------------------------------------------------------------------
    logic [ADDR_W-1:0]     region_base_q = REGION_BASE_RST;
    logic [ADDR_W-1:0]     region_top_q  = REGION_TOP_RST;
    bit   [SLOT_W-1:0]     free_slots [NUM_PAGES];
    bit   [COUNT_BITS-1:0] page_refs  [NUM_PAGES];
    int unsigned           free_depth = 0;

    t_page_result pending_results [$];

    // Bench control and bookkeeping
    bit gaps_on      = 1'b1;   // random idling on both streams
    int hold_req     = 0;      // cycles of receiver hold-off asked by a test
    int hold_left    = 0;
    int stall_cycles = 0;
    int requests_done = 0;
    int inits_done    = 0;
    int results_seen  = 0;
    int mismatches    = 0;

    // Region base rounded up to a page; kept at 64 bits so a base near the
    // top of the address space rounds past 2^40 instead of wrapping.
    function automatic logic [63:0] eff_base(input logic [ADDR_W-1:0] base);
        return ({24'd0, base} + PAGE_MASK) & ~PAGE_MASK;
    endfunction

    // Applies one request to the model and returns its result
    function automatic t_page_result apply_page_op(input t_opcode op,
                                                   input logic [ADDR_W-1:0] addr);
        t_page_result res;
        logic [63:0]  base64;
        logic [63:0]  addr64;
        logic [63:0]  span;
        int unsigned  slot;
        res    = '0;
        base64 = eff_base(region_base_q);
        addr64 = {24'd0, addr};
        case (op)
            OP_INIT: begin
                span = '0;
                if ({24'd0, region_top_q} > base64)
                    span = ({24'd0, region_top_q} - base64) >> PAGE_SHIFT;
                if (span > NUM_PAGES)
                    span = 64'(NUM_PAGES);
                // ascending push, so the highest page ends on top
                for (int i = 0; i < NUM_PAGES; i++) begin
                    page_refs[i] = '0;
                    if (i < span)
                        free_slots[i] = SLOT_W'(i);
                end
                free_depth = 32'(span);
            end
            OP_ALLOC: begin
                if (free_depth == 0) begin
                    res.status = STAT_OOM;
                end else begin
                    free_depth--;
                    slot = 32'(free_slots[free_depth]);
                    page_refs[slot] = COUNT_BITS'(1);
                    res.new_count = CNT_OUT_W'(1);
                    res.result_address = ADDR_W'(base64 + (64'(slot) << PAGE_SHIFT));
                end
            end
            default: begin
                if (addr64[PAGE_SHIFT-1:0] != 0 || addr64 < base64 || addr >= region_top_q
                        || ((addr64 - base64) >> PAGE_SHIFT) >= NUM_PAGES) begin
                    res.status = STAT_BAD_ADDR;
                end else begin
                    slot = int'((addr64 - base64) >> PAGE_SHIFT);
                    if (op == OP_INCREF) begin
                        if (page_refs[slot] == COUNT_MAX)
                            res.status = STAT_CNT_ERR;
                        else
                            page_refs[slot]++;
                    end else if (page_refs[slot] == 0) begin
                        res.status = STAT_CNT_ERR;
                    end else begin
                        page_refs[slot]--;
                        // a full stack silently drops the push
                        if (page_refs[slot] == 0 && free_depth < NUM_PAGES) begin
                            free_slots[free_depth] = SLOT_W'(slot);
                            free_depth++;
                            res.page_freed = 1'b1;
                        end
                    end
                    res.new_count = page_refs[slot];
                end
            end
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Input side monitor: register writes and accepted requests feed the model
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_REGION_BASE)
                    region_base_q = i_cfg_data;
                else
                    region_top_q = i_cfg_data;
            end
            if (i_s_tvalid && o_s_tready) begin
                pending_results.push_back(apply_page_op(t_opcode'(i_s_tuser), i_s_tdata));
                requests_done++;
                if (t_opcode'(i_s_tuser) == OP_INIT)
                    inits_done++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result checker: each result transfer against the oldest prediction
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string field, input logic [63:0] want,
                                   input logic [63:0] got);
        $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
        mismatches++;
    endtask

    always @(posedge i_clk) begin : check_results
        t_page_result got;
        t_page_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = o_m_tdata[RES_W-1:0];
            results_seen++;
            if (o_m_tdata[M_TDATA_W-1:RES_W] != '0)
                report_mismatch("tdata padding", 64'd0, 64'(o_m_tdata[M_TDATA_W-1:RES_W]));
            if (pending_results.size() == 0) begin
                $display("%0t ns: result with no request pending, expected none, actual 0x%0h",
                         $time, o_m_tdata);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (got.result_address != want.result_address)
                    report_mismatch("result_address", 64'(want.result_address),
                                    64'(got.result_address));
                if (got.status != want.status)
                    report_mismatch("status", 64'(want.status), 64'(got.status));
                if (got.page_freed != want.page_freed)
                    report_mismatch("page_freed", 64'(want.page_freed), 64'(got.page_freed));
                if (got.new_count != want.new_count)
                    report_mismatch("new_count", 64'(want.new_count), 64'(got.new_count));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: random tready, or a counted hold-off when a test asks for one
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= !gaps_on || ($urandom_range(99) >= 29);
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: too long without any transfer on any channel ends the run
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t ns: no transfer for %0d cycles, %0d results outstanding",
                         $time, stall_cycles, pending_results.size());
                $display("FAIL refcounted_page_allocator_core");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    // One request transfer, with random idle cycles in front of it
    task automatic send_page_op(input t_opcode op, input logic [ADDR_W-1:0] addr);
        @(negedge i_clk);
        while (gaps_on && $urandom_range(99) < 29) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= addr;
        i_s_tuser  <= op;
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    function automatic logic [ADDR_W-1:0] random_addr();
        return {8'($urandom), 32'($urandom)};
    endfunction

    // Waits until every predicted result has come back and the block is idle
    task automatic drain_results();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [ADDR_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // New region and a fresh pool; registers only change once idle
    task automatic setup_pool(input logic [ADDR_W-1:0] base, input logic [ADDR_W-1:0] top);
        drain_results();
        write_reg(CFG_REGION_BASE, base);
        write_reg(CFG_REGION_TOP, top);
        send_page_op(OP_INIT, random_addr());
    endtask

    // Stimulus address: mostly pages in or just past the pool, preferring
    // pages that are currently held, with some misaligned and wild ones.
    function automatic logic [ADDR_W-1:0] pick_page_addr(input int unsigned pool_pages);
        int unsigned held [$];
        int unsigned slot;
        int          pick;
        logic [63:0] base64;
        base64 = eff_base(region_base_q);
        pick   = $urandom_range(99);
        if (pick < 10)
            return random_addr();
        for (int unsigned s = 0; s < pool_pages; s++)
            if (page_refs[s] != 0)
                held.push_back(s);
        if (pick < 70 && held.size() != 0)
            slot = held[$urandom_range(held.size() - 1)];
        else
            slot = $urandom_range(pool_pages + 1);
        if (pick < 18)
            return ADDR_W'(base64 + (64'(slot) << PAGE_SHIFT)
                           + $urandom_range(1, 32'(PAGE_MASK)));
        return ADDR_W'(base64 + (64'(slot) << PAGE_SHIFT));
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Reset region, no init yet: the stack is empty and counts are zero
    task automatic test_empty_pool_after_reset();
        send_page_op(OP_ALLOC,  random_addr());         // out of memory
        send_page_op(OP_DECREF, 40'h00_8000_0000);      // decref at zero
        send_page_op(OP_INCREF, 40'h00_8000_0000);      // page never allocated
        send_page_op(OP_DECREF, 40'h00_8000_0000);      // pushed onto the empty stack
        send_page_op(OP_ALLOC,  random_addr());         // pops it back
        send_page_op(OP_ALLOC,  random_addr());
        send_page_op(OP_INCREF, 40'h00_8000_0800);      // misaligned
        send_page_op(OP_INCREF, 40'h00_7FFF_F000);      // below base
        send_page_op(OP_DECREF, 40'h00_8800_0000);      // at region top
        send_page_op(OP_INCREF, 40'h00_87FF_F000);      // last page
        send_page_op(OP_DECREF, 40'hFF_FFFF_FFFF);
        send_page_op(OP_INCREF, 40'h00_0000_0000);
    endtask

    // Unaligned base, three whole pages and a partial one
    task automatic test_small_pool();
        setup_pool(40'h00_0000_1234, 40'h00_0000_5800);
        repeat (4) send_page_op(OP_ALLOC, random_addr());  // top down, then empty
        send_page_op(OP_INCREF, 40'h00_0000_3000);
        send_page_op(OP_DECREF, 40'h00_0000_3000);
        send_page_op(OP_DECREF, 40'h00_0000_3000);      // back to the stack
        send_page_op(OP_DECREF, 40'h00_0000_3000);      // underflow
        send_page_op(OP_INCREF, 40'h00_0000_5000);      // partial page below top
        send_page_op(OP_INCREF, 40'h00_0000_1000);      // below rounded base
        send_page_op(OP_ALLOC,  random_addr());
    endtask

    // Range much larger than the pool: the stack starts full
    task automatic test_oversized_pool();
        setup_pool(40'h00_0000_0000, 40'hFF_FFFF_FFFF);
        send_page_op(OP_INCREF, 40'h00_0000_5000);      // page still on the stack
        send_page_op(OP_DECREF, 40'h00_0000_5000);      // push dropped, stack full
        send_page_op(OP_ALLOC,  random_addr());
        send_page_op(OP_DECREF, 40'h00_07FF_F000);
        send_page_op(OP_INCREF, 40'h00_0800_0000);      // index past the pool
        send_page_op(OP_ALLOC,  random_addr());
    endtask

    // Empty, inverted, and a base that rounds past the address space
    task automatic test_degenerate_ranges();
        setup_pool(40'h40_0000_0000, 40'h40_0000_0000);
        send_page_op(OP_ALLOC, random_addr());
        setup_pool(40'h50_0000_0000, 40'h40_0000_0000);
        send_page_op(OP_ALLOC,  random_addr());
        send_page_op(OP_INCREF, 40'h50_0000_0000);
        setup_pool(40'hFF_FFFF_F001, 40'hFF_FFFF_FFFF);
        send_page_op(OP_ALLOC,  random_addr());
        send_page_op(OP_INCREF, 40'hFF_FFFF_F000);
    endtask

    // Base moved after init: alloc addresses follow the new base and wrap
    task automatic test_moved_base();
        setup_pool(40'h00_0000_0000, 40'h00_0000_4000);
        drain_results();
        write_reg(CFG_REGION_BASE, 40'hFF_FFFF_E000);
        repeat (3) send_page_op(OP_ALLOC, random_addr());
        send_page_op(OP_INCREF, 40'hFF_FFFF_F000);      // above region top
        drain_results();
        write_reg(CFG_REGION_TOP, 40'hFF_FFFF_FFFF);
        send_page_op(OP_DECREF, 40'hFF_FFFF_F000);
        send_page_op(OP_ALLOC,  random_addr());
    endtask

    // Random region, fresh pool, then a random mix of requests
    task automatic test_random_phase(input int num_ops, input bit with_gaps,
                                     input bit with_holdoff);
        int unsigned       pool_pages;
        logic [ADDR_W-1:0] base;
        logic [63:0]       base64;
        int                pick;
        pool_pages = $urandom_range(1, 40);
        base       = {8'($urandom_range(254)), 32'($urandom)};
        base64     = eff_base(base);
        gaps_on    = with_gaps;
        setup_pool(base, ADDR_W'(base64 + (64'(pool_pages) << PAGE_SHIFT)
                                 + $urandom_range(32'(PAGE_MASK))));
        for (int n = 0; n < num_ops; n++) begin
            if (with_holdoff && n == num_ops / 4)
                hold_req = HOLDOFF_LEN;
            pick = $urandom_range(99);
            if (pick < 38)
                send_page_op(OP_ALLOC, random_addr());
            else if (pick < 60)
                send_page_op(OP_INCREF, pick_page_addr(pool_pages));
            else
                send_page_op(OP_DECREF, pick_page_addr(pool_pages));
        end
        gaps_on = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_pool_after_reset();
        test_small_pool();
        test_oversized_pool();
        test_degenerate_ranges();
        test_moved_base();
        test_random_phase(100, 1'b1, 1'b0);
        test_random_phase(100, 1'b0, 1'b0);
        test_random_phase(100, 1'b1, 1'b1);
        test_random_phase(100, 1'b1, 1'b0);
        test_random_phase(100, 1'b1, 1'b0);
        drain_results();

        $display("Covered %0d requests (%0d pool inits) over empty, small, oversized,",
                 requests_done, inits_done);
        $display("degenerate, moved and random regions; %0d results compared, %0d mismatches",
                 results_seen, mismatches);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("PASS refcounted_page_allocator_core");
        else
            $display("FAIL refcounted_page_allocator_core");
        $finish;
    end

endmodule

// File: refcounted_page_allocator_core.f
sv/rpa_pkg.sv
sv/rpa_ram.sv
sv/rpa_ctrl.sv
sv/rpa_dp.sv
sv/refcounted_page_allocator_core.sv
tb/sv/tb_refcounted_page_allocator_core.sv
